// File: rtl/core/offset_stats_overlap_tuner_assert.svh
// ----------------------------------------------------------------------------
// Offset statistics overlap tuner: assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef OFFSET_STATS_OVERLAP_TUNER_ASSERT_SVH
`define OFFSET_STATS_OVERLAP_TUNER_ASSERT_SVH
`ifndef ASSERT_OFF
`define OSOT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("offset stats tuner assertion failed");
`define OSOT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("offset stats tuner assertion failed");
`else
`define OSOT_ASSERT(label, clk, rst, prop)
`define OSOT_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: rtl/core/osot_pkg.sv
// ----------------------------------------------------------------------------
// Offset statistics overlap tuner package
// Payload structs, sequencer states, request kinds and register indexes.
// ----------------------------------------------------------------------------
package osot_pkg;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [23:0] value;
   } req_type;

   typedef struct packed {
      logic               overlap_updated;
      logic [15:0]        overlap;
      logic               drift_detected;
      logic signed [23:0] drift_step;
      logic signed [31:0] total_drift;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD,
      S_DECIDE,
      S_AVG_DIV,
      S_AVG_CHK,
      S_Q_DIV,
      S_DRIFT,
      S_OV_START,
      S_OV_DIV,
      S_OV_MIN,
      S_OV_MAX,
      S_DONE
   } state_type;

   localparam logic [1:0] KIND_SET1 = 2'd0;
   localparam logic [1:0] KIND_SET2 = 2'd1;

   localparam int CsrIndexWidth = 8;
   localparam logic [CsrIndexWidth-1:0] CSR_SECTOR   = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CSR_EPSILON  = CsrIndexWidth'(1);
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_OVL  = CsrIndexWidth'(2);
   localparam logic [CsrIndexWidth-1:0] CSR_INIT_OVL = CsrIndexWidth'(3);

   localparam logic [15:0] SectorReset  = 16'd1176;
   localparam logic [15:0] EpsilonReset = 16'd128;
   localparam logic [15:0] MaxOvlReset  = 16'd37632;
   localparam logic [15:0] InitOvlReset = 16'd37632;

   localparam int DivWidth    = 40;
   localparam int DivCntWidth = $clog2(DivWidth);
   localparam logic [DivCntWidth-1:0] DivLastCount = DivCntWidth'(DivWidth - 1);

   localparam logic [6:0]  AdjustNew1    = 7'd10;
   localparam logic [15:0] AdjustNew2    = 16'd10;
   localparam logic [15:0] Set2MinPoints = 16'd10;
   localparam logic [6:0]  Set1HalveAbove = 7'd50;

endpackage

// File: rtl/core/offset_stats_overlap_tuner.sv
// Sequence: an accepted request passes S_ADD and S_DECIDE, and its result is registered in S_DONE;
// an adjust pass runs the divider states, S_DRIFT when the drift check fires, and the overlap states.
// Flow: one request at a time; the 40-step shared restoring divider is run up to three times per
// adjust pass, and a result waits in S_DONE while the previous response is still held.
// A new request is taken once the result is registered, while that result may still wait.
// Reset: synchronous, active high; statistics clear and the overlap takes its reset value.
// ----------------------------------------------------------------------------
// Offset statistics overlap tuner
// Running offset statistics with drift correction and dynamic overlap tuning.
// ----------------------------------------------------------------------------
`include "offset_stats_overlap_tuner_assert.svh"

module offset_stats_overlap_tuner (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  osot_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output osot_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [osot_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [15:0]                          csr_wdata
);
   import osot_pkg::*;

   state_type state_ff, state_in;

   logic [15:0] sector_ff, sector_in;
   logic [15:0] eps_ff, eps_in;
   logic [15:0] maxov_ff, maxov_in;

   logic [6:0]         set1_points_ff, set1_points_in;
   logic [6:0]         set1_new_ff, set1_new_in;
   logic signed [31:0] set1_sum_ff, set1_sum_in;
   logic [31:0]        set1_absdiff_ff, set1_absdiff_in;
   logic signed [23:0] set1_min_ff, set1_min_in;
   logic signed [23:0] set1_max_ff, set1_max_in;
   logic [15:0]        set2_points_ff, set2_points_in;
   logic [15:0]        set2_new_ff, set2_new_in;
   logic signed [39:0] set2_sum_ff, set2_sum_in;
   logic [39:0]        set2_absdiff_ff, set2_absdiff_in;
   logic signed [23:0] set2_min_ff, set2_min_in;
   logic signed [23:0] set2_max_ff, set2_max_in;
   logic [15:0]        overlap_now_ff, overlap_now_in;
   logic signed [31:0] drift_total_ff, drift_total_in;

   logic [1:0]             kind_ff, kind_in;
   logic signed [23:0]     value_ff, value_in;
   logic [DivWidth-1:0]    div_num_ff, div_num_in;
   logic [15:0]            div_rem_ff, div_rem_in;
   logic [15:0]            div_den_ff, div_den_in;
   logic [DivCntWidth-1:0] div_cnt_ff, div_cnt_in;
   logic                   av_neg_ff, av_neg_in;
   logic [23:0]            mag_ff, mag_in;
   logic [33:0]            d_ff, d_in;
   logic                   ov_upd_ff, ov_upd_in;
   logic                   drift_ff, drift_in;
   logic signed [23:0]     step_ff, step_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [23:0]        abs_v;
   logic [32:0]        abs1_sum;
   logic [32:0]        sum1;
   logic [40:0]        abs2_sum;
   logic [40:0]        sum2;
   logic [39:0]        sum2_mag;
   logic [16:0]        div_trial;
   logic               div_ge;
   logic [23:0]        avg_mag;
   logic               drift_fire;
   logic [15:0]        eps_eff;
   logic [23:0]        qmag;
   logic signed [23:0] step_val;
   logic [32:0]        total_sum;
   logic [33:0]        d3;
   logic [23:0]        neg_min;
   logic [25:0]        x3;
   logic [25:0]        m3;
   logic [33:0]        d_a;
   logic [33:0]        d_b;
   logic [33:0]        d_lo;
   logic [33:0]        d_hi;
   logic signed [31:0] sum1_shr;
   logic [31:0]        half_sum;
   logic               run_adjust;

   // Sample statistics arithmetic.
   assign abs_v    = value_ff[23] ? 24'(-value_ff) : 24'(value_ff);
   assign abs1_sum = {1'b0, set1_absdiff_ff} + {9'b0, abs_v};
   assign sum1     = {set1_sum_ff[31], set1_sum_ff} + {{9{value_ff[23]}}, value_ff};
   assign abs2_sum = {1'b0, set2_absdiff_ff} + {17'b0, abs_v};
   assign sum2     = {set2_sum_ff[39], set2_sum_ff} + {{17{value_ff[23]}}, value_ff};
   assign sum2_mag = set2_sum_ff[39] ? 40'(-set2_sum_ff) : 40'(set2_sum_ff);

   // Shared restoring divider step: one quotient bit per cycle.
   assign div_trial = {div_rem_ff, div_num_ff[DivWidth-1]};
   assign div_ge    = div_trial >= {1'b0, div_den_ff};

   // Drift check: saturate the set-2 average to 24 bits and quantise it toward zero.
   always_comb begin
      if (av_neg_ff) begin
         avg_mag = (div_num_ff > 40'h80_0000) ? 24'h80_0000 : div_num_ff[23:0];
      end else begin
         avg_mag = (div_num_ff > 40'h7F_FFFF) ? 24'h7F_FFFF : div_num_ff[23:0];
      end
   end
   assign drift_fire = (avg_mag > {10'b0, overlap_now_ff[15:2]}) &&
                       (avg_mag > {8'b0, sector_ff});
   assign eps_eff    = (eps_ff == 16'd0) ? 16'd1 : eps_ff;
   assign qmag       = mag_ff - {8'b0, div_rem_ff};
   assign step_val   = av_neg_ff ? -$signed(qmag) : $signed(qmag);
   assign total_sum  = {drift_total_ff[31], drift_total_ff} + {{9{step_val[23]}}, step_val};

   // Overlap check: three times the mean, raised by the extremes, then clamped.
   assign d3      = {2'b0, div_num_ff[31:0]} + {1'b0, div_num_ff[31:0], 1'b0};
   assign neg_min = 24'(-set1_min_ff);
   assign x3      = {2'b0, neg_min} + {1'b0, neg_min, 1'b0};
   assign d_a     = ({d3, 1'b0} < {9'b0, x3}) ? {9'b0, x3[25:1]} : d3;
   assign m3      = {2'b0, set1_max_ff[23:0]} + {1'b0, set1_max_ff[23:0], 1'b0};
   assign d_b     = ({d_ff, 1'b0} < {9'b0, m3}) ? {9'b0, m3[25:1]} : d_ff;
   assign d_lo    = (d_b < {18'b0, eps_ff}) ? {18'b0, eps_ff} : d_b;
   assign d_hi    = (d_lo > {18'b0, maxov_ff}) ? {18'b0, maxov_ff} : d_lo;
   assign sum1_shr = set1_sum_ff >>> 1;
   assign half_sum = sum1_shr + {31'b0, set1_sum_ff[31] & set1_sum_ff[0]};

   assign run_adjust = ((kind_ff != KIND_SET1) && (kind_ff != KIND_SET2)) ||
                       ((kind_ff == KIND_SET1) && (set1_new_ff >= AdjustNew1)) ||
                       ((kind_ff == KIND_SET2) && (set2_new_ff >= AdjustNew2));

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in        = state_ff;
      sector_in       = sector_ff;
      eps_in          = eps_ff;
      maxov_in        = maxov_ff;
      set1_points_in  = set1_points_ff;
      set1_new_in     = set1_new_ff;
      set1_sum_in     = set1_sum_ff;
      set1_absdiff_in = set1_absdiff_ff;
      set1_min_in     = set1_min_ff;
      set1_max_in     = set1_max_ff;
      set2_points_in  = set2_points_ff;
      set2_new_in     = set2_new_ff;
      set2_sum_in     = set2_sum_ff;
      set2_absdiff_in = set2_absdiff_ff;
      set2_min_in     = set2_min_ff;
      set2_max_in     = set2_max_ff;
      overlap_now_in  = overlap_now_ff;
      drift_total_in  = drift_total_ff;
      kind_in         = kind_ff;
      value_in        = value_ff;
      div_num_in      = div_num_ff;
      div_rem_in      = div_rem_ff;
      div_den_in      = div_den_ff;
      div_cnt_in      = div_cnt_ff;
      av_neg_in       = av_neg_ff;
      mag_in          = mag_ff;
      d_in            = d_ff;
      ov_upd_in       = ov_upd_ff;
      drift_in        = drift_ff;
      step_in         = step_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      if (csr_we) begin
         case (csr_index)
            CSR_SECTOR:   sector_in = csr_wdata;
            CSR_EPSILON:  eps_in = csr_wdata;
            CSR_MAX_OVL:  maxov_in = csr_wdata;
            CSR_INIT_OVL: overlap_now_in = csr_wdata;
            default: ;
         endcase
      end

      // Every divider state advances the shared unit by one step.
      if ((state_ff == S_AVG_DIV) || (state_ff == S_Q_DIV) || (state_ff == S_OV_DIV)) begin
         div_rem_in = div_ge ? 16'(div_trial - {1'b0, div_den_ff}) : div_trial[15:0];
         div_num_in = {div_num_ff[DivWidth-2:0], div_ge};
         div_cnt_in = div_cnt_ff - DivCntWidth'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_data.kind;
               value_in  = req_data.value;
               ov_upd_in = 1'b0;
               drift_in  = 1'b0;
               step_in   = '0;
               state_in  = S_ADD;
            end
         end
         S_ADD: begin
            if (kind_ff == KIND_SET1) begin
               if (set1_points_ff != 7'd0) begin
                  set1_absdiff_in = abs1_sum[32] ? '1 : abs1_sum[31:0];
               end
               if (set1_points_ff != '1) set1_points_in = set1_points_ff + 7'd1;
               if (set1_new_ff != '1) set1_new_in = set1_new_ff + 7'd1;
               if (sum1[32] != sum1[31]) begin
                  set1_sum_in = sum1[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               end else begin
                  set1_sum_in = sum1[31:0];
               end
               if (value_ff < set1_min_ff) set1_min_in = value_ff;
               if (value_ff > set1_max_ff) set1_max_in = value_ff;
            end else if (kind_ff == KIND_SET2) begin
               if (set2_points_ff != 16'd0) begin
                  set2_absdiff_in = abs2_sum[40] ? '1 : abs2_sum[39:0];
               end
               if (set2_points_ff != '1) set2_points_in = set2_points_ff + 16'd1;
               if (set2_new_ff != '1) set2_new_in = set2_new_ff + 16'd1;
               if (sum2[40] != sum2[39]) begin
                  set2_sum_in = sum2[40] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF;
               end else begin
                  set2_sum_in = sum2[39:0];
               end
               if (value_ff < set2_min_ff) set2_min_in = value_ff;
               if (value_ff > set2_max_ff) set2_max_in = value_ff;
            end
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!run_adjust) begin
               state_in = S_DONE;
            end else if (set2_points_ff >= Set2MinPoints) begin
               div_num_in = sum2_mag;
               div_den_in = set2_points_ff;
               div_rem_in = '0;
               div_cnt_in = DivLastCount;
               av_neg_in  = set2_sum_ff[39];
               state_in   = S_AVG_DIV;
            end else begin
               state_in = S_OV_START;
            end
         end
         S_AVG_DIV: begin
            if (div_cnt_ff == '0) state_in = S_AVG_CHK;
         end
         S_AVG_CHK: begin
            mag_in = avg_mag;
            if (drift_fire) begin
               div_num_in = {16'b0, avg_mag};
               div_den_in = eps_eff;
               div_rem_in = '0;
               div_cnt_in = DivLastCount;
               state_in   = S_Q_DIV;
            end else begin
               state_in = S_OV_START;
            end
         end
         S_Q_DIV: begin
            if (div_cnt_ff == '0) state_in = S_DRIFT;
         end
         S_DRIFT: begin
            drift_in = 1'b1;
            step_in  = step_val;
            if (total_sum[32] != total_sum[31]) begin
               drift_total_in = total_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
               drift_total_in = total_sum[31:0];
            end
            set2_points_in  = '0;
            set2_new_in     = '0;
            set2_sum_in     = '0;
            set2_absdiff_in = '0;
            set2_min_in     = '0;
            set2_max_in     = '0;
            state_in        = S_OV_START;
         end
         S_OV_START: begin
            if (set1_points_ff != 7'd0) begin
               div_num_in = {8'b0, set1_absdiff_ff};
               div_den_in = {9'b0, set1_points_ff};
               div_rem_in = '0;
               div_cnt_in = DivLastCount;
               state_in   = S_OV_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_OV_DIV: begin
            if (div_cnt_ff == '0) state_in = S_OV_MIN;
         end
         S_OV_MIN: begin
            d_in     = d_a;
            state_in = S_OV_MAX;
         end
         S_OV_MAX: begin
            overlap_now_in = d_hi[15:0];
            ov_upd_in      = 1'b1;
            if (set1_points_ff > Set1HalveAbove) begin
               set1_points_in  = {1'b0, set1_points_ff[6:1]};
               set1_sum_in     = $signed(half_sum);
               set1_absdiff_in = {1'b0, set1_absdiff_ff[31:1]};
            end
            set1_min_in = '0;
            set1_max_in = '0;
            set1_new_in = '0;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.overlap_updated = ov_upd_ff;
               rsp_in.overlap         = overlap_now_ff;
               rsp_in.drift_detected  = drift_ff;
               rsp_in.drift_step      = step_ff;
               rsp_in.total_drift     = drift_total_ff;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_ff       <= SectorReset;
         eps_ff          <= EpsilonReset;
         maxov_ff        <= MaxOvlReset;
         set1_points_ff  <= '0;
         set1_new_ff     <= '0;
         set1_sum_ff     <= '0;
         set1_absdiff_ff <= '0;
         set1_min_ff     <= '0;
         set1_max_ff     <= '0;
         set2_points_ff  <= '0;
         set2_new_ff     <= '0;
         set2_sum_ff     <= '0;
         set2_absdiff_ff <= '0;
         set2_min_ff     <= '0;
         set2_max_ff     <= '0;
         overlap_now_ff  <= InitOvlReset;
         drift_total_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sector_ff       <= sector_in;
         eps_ff          <= eps_in;
         maxov_ff        <= maxov_in;
         set1_points_ff  <= set1_points_in;
         set1_new_ff     <= set1_new_in;
         set1_sum_ff     <= set1_sum_in;
         set1_absdiff_ff <= set1_absdiff_in;
         set1_min_ff     <= set1_min_in;
         set1_max_ff     <= set1_max_in;
         set2_points_ff  <= set2_points_in;
         set2_new_ff     <= set2_new_in;
         set2_sum_ff     <= set2_sum_in;
         set2_absdiff_ff <= set2_absdiff_in;
         set2_min_ff     <= set2_min_in;
         set2_max_ff     <= set2_max_in;
         overlap_now_ff  <= overlap_now_in;
         drift_total_ff  <= drift_total_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      div_cnt_ff <= div_cnt_in;
      av_neg_ff  <= av_neg_in;
      mag_ff     <= mag_in;
      d_ff       <= d_in;
      ov_upd_ff  <= ov_upd_in;
      drift_ff   <= drift_in;
      step_ff    <= step_in;
      rsp_ff     <= rsp_in;
   end

   `OSOT_ASSERT_NEXT(a_accept_starts_add, clock, reset, req_valid && req_ready, state_ff == S_ADD)
   `OSOT_ASSERT_NEXT(a_done_hands_over, clock, reset, (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == S_IDLE))
   `OSOT_ASSERT(a_no_drift_no_step, clock, reset, rsp_valid_ff && !rsp_ff.drift_detected |-> rsp_ff.drift_step == 24'sd0)
   `OSOT_ASSERT(a_set1_extremes, clock, reset, (set1_min_ff <= 24'sd0) && (set1_max_ff >= 24'sd0))

endmodule

// File: test/offset_stats_checker.sv
// ----------------------------------------------------------------------------
// Offset statistics overlap tuner: response checker
// Watches the request, response and register ports, keeps its own copy of the
// statistics, drift total and overlap, and compares every response field with
// the value predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module offset_stats_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  osot_pkg::req_type                    req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  osot_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [osot_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [15:0]                          csr_wdata,
   output int                                   errors,
   output int                                   awaited,
   output int                                   request_count,
   output int                                   drift_count,
   output int                                   overlap_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import osot_pkg::*;

   localparam int unsigned AdjustAfter  = 10;
   localparam int unsigned HalveAbove   = 50;
   localparam int unsigned Set1CountMax = 127;
   localparam int unsigned Set2CountMax = 65535;
   localparam longint S24Max = 64'sd8388607;
   localparam longint S24Min = -64'sd8388608;
   localparam longint S32Max = 64'sd2147483647;
   localparam longint S32Min = -64'sd2147483648;
   localparam longint S40Max = 64'sd549755813887;
   localparam longint S40Min = -64'sd549755813888;
   localparam longint U32Max = 64'sd4294967295;
   localparam longint U40Max = 64'sd1099511627775;

   logic [15:0] sector_words, epsilon_words, max_overlap_words;
   int unsigned s1_points, s1_new, s2_points, s2_new;
   longint      s1_sum, s1_abs, s1_min, s1_max;
   longint      s2_sum, s2_abs, s2_min, s2_max;
   logic [15:0] overlap_now;
   longint      drift_total;
   rsp_type     expected_q[$];
   int          fails, drifts, updates, requests;

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic rsp_type predict_request(req_type item);
      longint  v, mag, av, q, d;
      logic    run;
      rsp_type res;
      v = $signed(item.value);
      mag = (v < 0) ? -v : v;
      res = '0;
      if (item.kind == KIND_SET1) begin
         // The very first sample of a set adds nothing to its absolute sum.
         if (s1_points != 0) s1_abs = clip(s1_abs + mag, 0, U32Max);
         if (s1_points < Set1CountMax) s1_points++;
         if (s1_new < Set1CountMax) s1_new++;
         s1_sum = clip(s1_sum + v, S32Min, S32Max);
         if (v < s1_min) s1_min = v;
         if (v > s1_max) s1_max = v;
         run = (s1_new >= AdjustAfter);
      end else if (item.kind == KIND_SET2) begin
         if (s2_points != 0) s2_abs = clip(s2_abs + mag, 0, U40Max);
         if (s2_points < Set2CountMax) s2_points++;
         if (s2_new < Set2CountMax) s2_new++;
         s2_sum = clip(s2_sum + v, S40Min, S40Max);
         if (v < s2_min) s2_min = v;
         if (v > s2_max) s2_max = v;
         run = (s2_new >= AdjustAfter);
      end else begin
         run = 1'b1;
      end

      if (run && s2_points >= AdjustAfter) begin
         av = clip(s2_sum / longint'(s2_points), S24Min, S24Max);
         mag = (av < 0) ? -av : av;
         if (mag > longint'(overlap_now >> 2) && mag > longint'(sector_words)) begin
            q = (epsilon_words == '0) ? 64'sd1 : longint'(epsilon_words);
            av = (av / q) * q;
            res.drift_detected = 1'b1;
            res.drift_step = av[23:0];
            drift_total = clip(drift_total + av, S32Min, S32Max);
            s2_points = 0;
            s2_new = 0;
            s2_sum = 0;
            s2_abs = 0;
            s2_min = 0;
            s2_max = 0;
            drifts++;
         end
      end

      if (run && s1_points != 0) begin
         d = (s1_abs / longint'(s1_points)) * 3;
         if (2 * d < -3 * s1_min) d = (-3 * s1_min) / 2;
         if (2 * d < 3 * s1_max) d = (3 * s1_max) / 2;
         if (d < longint'(epsilon_words)) d = longint'(epsilon_words);
         // The upper clamp is applied last, so it wins when the bounds cross.
         if (d > longint'(max_overlap_words)) d = longint'(max_overlap_words);
         overlap_now = d[15:0];
         res.overlap_updated = 1'b1;
         if (s1_points > HalveAbove) begin
            s1_points = s1_points / 2;
            s1_sum = s1_sum / 2;
            s1_abs = s1_abs / 2;
         end
         s1_min = 0;
         s1_max = 0;
         s1_new = 0;
         updates++;
      end

      res.overlap = overlap_now;
      res.total_drift = drift_total[31:0];
      return res;
   endfunction

   function automatic void compare_field(string field, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         sector_words = SectorReset;
         epsilon_words = EpsilonReset;
         max_overlap_words = MaxOvlReset;
         overlap_now = InitOvlReset;
         s1_points = 0;
         s1_new = 0;
         s1_sum = 0;
         s1_abs = 0;
         s1_min = 0;
         s1_max = 0;
         s2_points = 0;
         s2_new = 0;
         s2_sum = 0;
         s2_abs = 0;
         s2_min = 0;
         s2_max = 0;
         drift_total = 0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SECTOR:   sector_words = csr_wdata;
               CSR_EPSILON:  epsilon_words = csr_wdata;
               CSR_MAX_OVL:  max_overlap_words = csr_wdata;
               CSR_INIT_OVL: overlap_now = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response with no request outstanding, overlap %0d total drift %0d",
                        $time, rsp_data.overlap, $signed(rsp_data.total_drift));
               fails++;
            end else begin
               want = expected_q.pop_front();
               compare_field("overlap_updated", want.overlap_updated, rsp_data.overlap_updated);
               compare_field("overlap", want.overlap, rsp_data.overlap);
               compare_field("drift_detected", want.drift_detected, rsp_data.drift_detected);
               compare_field("drift_step", $signed(want.drift_step), $signed(rsp_data.drift_step));
               compare_field("total_drift", $signed(want.total_drift),
                             $signed(rsp_data.total_drift));
            end
         end
         if (req_valid && req_ready) begin
            expected_q.push_back(predict_request(req_data));
            requests++;
         end
      end
      errors <= fails;
      awaited <= expected_q.size();
      request_count <= requests;
      drift_count <= drifts;
      overlap_count <= updates;
   end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Offset statistics overlap tuner testbench
// Drives directed and random offset requests through several register
// settings, with random gaps on both channels and one long output stall, and
// reports the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import osot_pkg::*;

   localparam logic [1:0] KIND_ADJUST = 2'd2;
   localparam logic [1:0] KIND_SPARE  = 2'd3;
   localparam int WatchdogLimit = 5000;
   localparam int DrainCycles   = 150;
   localparam int HoldOffCycles = 400;
   localparam int HoldOffAfter  = 60;
   localparam int SectionQuota  = 120;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [15:0]              csr_wdata = '0;

   logic        quiet = 1'b0;
   int unsigned gap_odds = 3;
   int          settings_count = 0;
   int          idle_cycles = 0;
   int          fail_count, awaited, request_count, drift_count, overlap_count;

   always #5 clock = ~clock;

   offset_stats_overlap_tuner u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   offset_stats_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .errors        (fail_count),
      .awaited       (awaited),
      .request_count (request_count),
      .drift_count   (drift_count),
      .overlap_count (overlap_count)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no request or response moved for %0d cycles", $time, idle_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side: alternating stretches with and without stalls, and one
   // long hold-off once the run is under way so that the block backs up.
   initial begin
      int unsigned span;
      bit          stalls_on;
      bit          held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         span = $urandom_range(20, 200);
         stalls_on = ($urandom_range(0, 2) != 0);
         repeat (span) begin
            if (!held && request_count >= HoldOffAfter) begin
               held = 1'b1;
               rsp_ready <= 1'b0;
               repeat (HoldOffCycles) @(posedge clock);
            end else if (stalls_on && !quiet && $urandom_range(0, 3) == 0) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 18)) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Valid is left high after acceptance; it only drops for a gap or a drain.
   task automatic offer(input logic [1:0] kind, input logic [23:0] value);
      if (!quiet && $urandom_range(0, 7) < gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_data <= {kind, value};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] index, input logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [15:0] sector, input logic [15:0] eps,
                                input logic [15:0] max_ovl, input logic [15:0] init_ovl);
      write_reg(CSR_SECTOR, sector);
      write_reg(CSR_EPSILON, eps);
      write_reg(CSR_MAX_OVL, max_ovl);
      write_reg(CSR_INIT_OVL, init_ovl);
      settings_count++;
   endtask

   function automatic logic [23:0] random_offset(input int unsigned profile);
      int mag;
      mag = int'($urandom & ((32'd1 << $urandom_range(0, 23)) - 1));
      case (profile)
         0: return 24'($urandom);
         1: return 24'($urandom_range(0, 600) - 300);
         2: return ($urandom_range(0, 1) != 0) ? 24'(-mag) : 24'(mag);
         default: begin
            case ($urandom_range(0, 4))
               0: return 24'h7FFFFF;
               1: return 24'h800000;
               2: return 24'h000000;
               3: return 24'hFFFFFF;
               default: return 24'h000001;
            endcase
         end
      endcase
   endfunction

   task automatic random_traffic(input int quota);
      int          done_items;
      int          n;
      int          bias;
      int          spread;
      int          s;
      int unsigned profile;
      done_items = 0;
      while (done_items < quota) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               // A set-1 run long enough to trigger the overlap recomputation.
               profile = $urandom_range(0, 3);
               n = $urandom_range(10, 12);
               repeat (n) offer(KIND_SET1, random_offset(profile));
               done_items += n;
            end
            3, 4, 5: begin
               // A set-2 run scattered around a common mean, so that drift can fire.
               bias = int'($urandom & ((32'd1 << $urandom_range(0, 23)) - 1));
               if ($urandom_range(0, 1) != 0) bias = -bias;
               spread = ((bias < 0) ? -bias : bias) >> $urandom_range(1, 6);
               n = $urandom_range(10, 13);
               repeat (n) begin
                  s = bias + int'($urandom_range(0, 2 * spread)) - spread;
                  if (s > 8388607) s = 8388607;
                  if (s < -8388608) s = -8388608;
                  offer(KIND_SET2, 24'(s));
               end
               done_items += n;
            end
            6: begin
               offer(($urandom_range(0, 1) != 0) ? KIND_SPARE : KIND_ADJUST, 24'($urandom));
               done_items++;
            end
            7: begin
               // A run cut short and closed by an explicit adjust.
               n = $urandom_range(1, 9);
               repeat (n) offer(2'($urandom_range(0, 1)), random_offset($urandom_range(0, 3)));
               offer(KIND_ADJUST, random_offset(0));
               done_items += n + 1;
            end
            default: begin
               n = $urandom_range(1, 6);
               repeat (n) offer(2'($urandom_range(0, 3)), 24'($urandom));
               done_items += n;
            end
         endcase
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests at the reset settings.
      offer(KIND_ADJUST, 24'h000000);
      offer(KIND_SET1, 24'h7FFFFF);
      offer(KIND_SET1, 24'h800000);
      offer(KIND_SET1, 24'h000000);
      offer(KIND_SET1, 24'hFFFFFF);
      offer(KIND_ADJUST, 24'h123456);
      offer(KIND_SPARE, 24'hFFFFFF);
      repeat (10) offer(KIND_SET2, 24'h7FFFFF);
      offer(KIND_SET2, 24'h000001);
      offer(KIND_SET2, 24'h000000);
      offer(KIND_SET2, 24'h800000);
      offer(KIND_SPARE, 24'h000000);
      random_traffic(SectionQuota);
      settle();

      gap_odds = $urandom_range(0, 4);
      apply_setting(16'd1, 16'd1, 16'd65535, 16'd65535);
      random_traffic(SectionQuota);
      settle();

      // Epsilon above the maximum overlap: the clamps cross.
      gap_odds = $urandom_range(0, 4);
      apply_setting(16'd65535, 16'd65535, 16'd1, 16'd1);
      random_traffic(SectionQuota);
      settle();

      gap_odds = $urandom_range(0, 4);
      apply_setting(16'd300, 16'd0, 16'd5000, 16'd1234);
      write_reg(CsrIndexWidth'(CSR_INIT_OVL + 8'($urandom_range(1, 252))), 16'($urandom));
      random_traffic(SectionQuota);
      settle();

      repeat (2) begin
         gap_odds = $urandom_range(0, 4);
         apply_setting(16'($urandom_range(1, 20000)),
                       ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 65535))
                                                   : 16'($urandom_range(1, 300)),
                       16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
         random_traffic(SectionQuota);
         settle();
      end

      // Last part without gaps: full-scale drift corrections in both directions.
      quiet <= 1'b1;
      apply_setting(16'd1, 16'd0, 16'd65535, 16'($urandom_range(1, 65535)));
      repeat (3) repeat (10) offer(KIND_SET2, 24'h7FFFFF);
      repeat (3) repeat (10) offer(KIND_SET2, 24'h800000);
      random_traffic(60);
      settle();

      $display("Covered %0d requests under %0d register settings, ending with a gap-free stretch.",
               request_count, settings_count);
      $display("Checked %0d drift corrections and %0d overlap recomputations.",
               drift_count, overlap_count);
      if (fail_count == 0 && awaited == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
